// ===== rtl/lsd_pkg.sv =====
package lsd_pkg;

   localparam logic [2:0] KIND_EXT_LEN  = 3'd0;
   localparam logic [2:0] KIND_EXT_CHAR = 3'd1;
   localparam logic [2:0] KIND_PAY_SIZE = 3'd2;
   localparam logic [2:0] KIND_PAY_BYTE = 3'd3;
   localparam logic [2:0] KIND_MISMATCH = 3'd4;

   localparam logic [7:0] HEADER_BYTES_RESET = 8'd54;
   localparam logic [7:0] MAGIC_FIRST_RESET  = 8'd35;
   localparam logic [7:0] MAGIC_SECOND_RESET = 8'd42;

   localparam logic [1:0] CSR_HEADER_BYTES = 2'd0;
   localparam logic [1:0] CSR_MAGIC_FIRST  = 2'd1;
   localparam logic [1:0] CSR_MAGIC_SECOND = 2'd2;

   typedef struct packed {
      logic [7:0] image_byte;
      logic       restart;
   } item_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  kind;
      logic [31:0] value;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [7:0] header_bytes;
      logic [7:0] magic_first;
      logic [7:0] magic_second;
   } csr_type;

endpackage

// ===== rtl/lsd_decode.sv =====
module lsd_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  lsd_pkg::item_type   item,
   input  lsd_pkg::csr_type    csr,
   output lsd_pkg::result_type result
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_MAGIC,
      PH_EXT_LEN,
      PH_EXT_CHAR,
      PH_PAY_SIZE,
      PH_PAY_BYTE,
      PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  position_ff, position_in;
   logic [31:0] collector_ff, collector_in;
   logic [31:0] remaining_ff, remaining_in;

   phase_type   ph;
   logic [7:0]  pos;
   logic [31:0] col;
   logic [31:0] rem;
   logic [31:0] rem_dec;
   logic [7:0]  need;
   logic [7:0]  pos_inc;

   always_comb begin
      ph      = item.restart ? PH_HEADER : phase_ff;
      pos     = item.restart ? 8'd0 : position_ff;
      col     = item.restart ? 32'd0 : collector_ff;
      rem     = item.restart ? 32'd0 : remaining_ff;
      rem_dec = rem - 32'd1;
      need    = 8'd8;
      pos_inc = 8'd0;

      phase_in     = ph;
      position_in  = pos;
      collector_in = col;
      remaining_in = rem;
      result       = '0;

      if (ph == PH_HEADER && pos < csr.header_bytes) begin
         position_in = pos + 8'd1;
      end else begin
         if (ph == PH_HEADER) begin
            ph  = PH_MAGIC;
            pos = 8'd0;
            col = 32'd0;
         end
         phase_in     = ph;
         position_in  = pos;
         collector_in = col;
         if (ph != PH_DONE) begin
            col     = {col[30:0], item.image_byte[0]};
            pos_inc = pos + 8'd1;
            case (ph)
               PH_MAGIC:                 need = 8'd16;
               PH_EXT_LEN, PH_PAY_SIZE:  need = 8'd32;
               default:                  need = 8'd8;
            endcase
            collector_in = col;
            position_in  = pos_inc;
            if (pos_inc >= need) begin
               position_in  = 8'd0;
               collector_in = 32'd0;
               case (ph)
                  PH_MAGIC: begin
                     if (col[15:8] != csr.magic_first || col[7:0] != csr.magic_second) begin
                        phase_in = PH_DONE;
                        result   = '{1'b1, lsd_pkg::KIND_MISMATCH, 32'd0, 1'b1};
                     end else begin
                        phase_in = PH_EXT_LEN;
                     end
                  end
                  PH_EXT_LEN: begin
                     remaining_in = col;
                     phase_in     = (col != 32'd0) ? PH_EXT_CHAR : PH_PAY_SIZE;
                     result       = '{1'b1, lsd_pkg::KIND_EXT_LEN, col, 1'b0};
                  end
                  PH_EXT_CHAR: begin
                     remaining_in = rem_dec;
                     phase_in     = (rem_dec != 32'd0) ? PH_EXT_CHAR : PH_PAY_SIZE;
                     result       = '{1'b1, lsd_pkg::KIND_EXT_CHAR, {24'd0, col[7:0]}, 1'b0};
                  end
                  PH_PAY_SIZE: begin
                     remaining_in = col;
                     phase_in     = (col != 32'd0) ? PH_PAY_BYTE : PH_DONE;
                     result       = '{1'b1, lsd_pkg::KIND_PAY_SIZE, col, col == 32'd0};
                  end
                  default: begin
                     remaining_in = rem_dec;
                     phase_in     = (rem_dec != 32'd0) ? PH_PAY_BYTE : PH_DONE;
                     result       = '{1'b1, lsd_pkg::KIND_PAY_BYTE, {24'd0, col[7:0]},
                                      rem_dec == 32'd0};
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         position_ff  <= 8'd0;
         collector_ff <= 32'd0;
         remaining_ff <= 32'd0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         position_ff  <= position_in;
         collector_ff <= collector_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

// ===== rtl/lsb_stego_stream_decoder.sv =====
// LSB steganography stream decoder.
// Input channel (req_*): one image file byte per item, req_restart marks the
// first byte of a new image. Result channel (rsp_*): zero or one result per
// item, giving kind, 32-bit value and a last flag on the final record result.
// Configuration (csr_*): header length and the two magic characters. The user
// writes them only while the block is idle; the block does not enforce this.
// Path: an accepted byte lands in the input register, is decoded from there,
// and its result is loaded into the result register that drives rsp_valid.
// Throughput: one byte per cycle unless rsp_stall holds a result; decoding is
// one pass of shift, counter compare, phase update between the two registers.
// Reset: the decoder returns to header skip with cleared counters, and the
// registers take their defaults (54 header bytes, magic '#' and '*').
// Stall: while rsp_stall holds a result, the item in the input register waits
// and req_stall rises once the input register is also occupied.
module lsb_stego_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_image_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_value,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   lsd_pkg::csr_type    csr_ff;
   lsd_pkg::item_type   item_ff;
   logic                item_valid_ff;
   lsd_pkg::result_type result_in;
   lsd_pkg::result_type rsp_ff;
   logic                advance;
   logic                step_en;

   assign advance   = !rsp_ff.valid || !rsp_stall;
   assign step_en   = item_valid_ff && advance;
   assign req_stall = item_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.header_bytes <= lsd_pkg::HEADER_BYTES_RESET;
         csr_ff.magic_first  <= lsd_pkg::MAGIC_FIRST_RESET;
         csr_ff.magic_second <= lsd_pkg::MAGIC_SECOND_RESET;
      end else if (csr_write) begin
         case (csr_index)
            lsd_pkg::CSR_HEADER_BYTES: csr_ff.header_bytes <= csr_wdata;
            lsd_pkg::CSR_MAGIC_FIRST:  csr_ff.magic_first  <= csr_wdata;
            lsd_pkg::CSR_MAGIC_SECOND: csr_ff.magic_second <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         item_ff <= '{req_image_byte, req_restart};
      end
   end

   lsd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item_ff),
      .csr     (csr_ff),
      .result  (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else if (advance) begin
         rsp_ff.valid <= step_en && result_in.valid;
      end
      if (step_en && result_in.valid) begin
         rsp_ff.kind  <= result_in.kind;
         rsp_ff.value <= result_in.value;
         rsp_ff.last  <= result_in.last;
      end
   end

   assign rsp_valid = rsp_ff.valid;
   assign rsp_kind  = rsp_ff.kind;
   assign rsp_value = rsp_ff.value;
   assign rsp_last  = rsp_ff.last;

   a_mismatch_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == lsd_pkg::KIND_MISMATCH |-> rsp_last && rsp_value == 32'd0)
      else $error("mismatch result malformed");

   a_char_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == lsd_pkg::KIND_EXT_CHAR || rsp_kind == lsd_pkg::KIND_PAY_BYTE)
      |-> rsp_value[31:8] == 24'd0)
      else $error("character result wider than a byte");

   a_empty_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == lsd_pkg::KIND_PAY_SIZE && rsp_last |-> rsp_value == 32'd0)
      else $error("payload size marked last while nonzero");

   a_held_item: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !advance |=> item_valid_ff)
      else $error("waiting item dropped");

endmodule
